// ===== rtl/core/uvsp_pkg.sv =====
// ----------------------------------------------------------------------------
// uvsp_pkg
// Shared types, constants and helpers of the UV sphere point generator.
// ----------------------------------------------------------------------------
package uvsp_pkg;

    localparam int MAX_RINGS     = 256;
    localparam int MAX_SEGMENTS  = 256;
    localparam int CORDIC_STAGES = 16;
    localparam int DIV_BITS      = 32;
    localparam int CNT_W         = 9;
    localparam int IDX_W         = 17;
    localparam int ANG_W         = 34;
    localparam int COORD_W       = 17;
    localparam int PROD_W        = 53;

    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [PROD_W-1:0] COORD_LIMIT = 53'sd65535;

    typedef enum logic [1:0] {
        REG_RADIUS        = 2'd0,
        REG_RING_COUNT    = 2'd1,
        REG_SEGMENT_COUNT = 2'd2,
        REG_UNUSED        = 2'd3
    } cfg_idx_t;

    // Quad indices and flags that ride along with each point
    typedef struct packed {
        logic [IDX_W-1:0] first;
        logic [IDX_W-1:0] second;
        logic             quad;
        logic             last;
    } side_t;

    // Payload of one long-division cell
    typedef struct packed {
        logic [CNT_W-1:0]    rem_t;
        logic [CNT_W-1:0]    rem_p;
        logic [DIV_BITS-1:0] quo_t;
        logic [DIV_BITS-1:0] quo_p;
        logic                full_t;
        logic                full_p;
        side_t               side;
    } div_t;

    // Payload of one CORDIC cell: two rotations side by side
    typedef struct packed {
        logic signed [ANG_W-1:0] xt;
        logic signed [ANG_W-1:0] yt;
        logic signed [ANG_W-1:0] zt;
        logic signed [ANG_W-1:0] xp;
        logic signed [ANG_W-1:0] yp;
        logic signed [ANG_W-1:0] zp;
        logic                    neg_t;
        logic                    neg_p;
        side_t                   side;
    } cor_t;

    // Arctangent of 2^-k in binary angle units (2^32 per turn)
    function automatic logic signed [ANG_W-1:0] atan_turn(input logic [4:0] k);
        logic signed [ANG_W-1:0] v;
        case (k)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clamp a coordinate to the symmetric Q8.8 range
    function automatic logic signed [COORD_W-1:0] sat_coord(
        input logic signed [PROD_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > COORD_LIMIT) begin
            r = 17'sd65535;
        end else if (v < -COORD_LIMIT) begin
            r = -17'sd65535;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/uvsp_div_cell.sv =====
// ----------------------------------------------------------------------------
// uvsp_div_cell
// One bit of the restoring long division that turns indices into angles.
// ----------------------------------------------------------------------------
module uvsp_div_cell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  uvsp_pkg::div_t              in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output uvsp_pkg::div_t              out_data,
    input  logic [uvsp_pkg::CNT_W-1:0]  den_t,
    input  logic [uvsp_pkg::CNT_W-1:0]  den_p
);

    logic           valid_reg;
    uvsp_pkg::div_t data_reg;
    uvsp_pkg::div_t data_next;
    logic [uvsp_pkg::CNT_W:0] dbl_t;
    logic [uvsp_pkg::CNT_W:0] dbl_p;
    logic           bit_t;
    logic           bit_p;

    // Move on when this cell is empty or its neighbor takes the data
    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // Shift remainder, subtract denominator when it fits
    always_comb begin
        dbl_t = {in_data.rem_t, 1'b0};
        dbl_p = {in_data.rem_p, 1'b0};
        bit_t = dbl_t >= {1'b0, den_t};
        bit_p = dbl_p >= {1'b0, den_p};
        data_next = in_data;
        data_next.rem_t = bit_t ? uvsp_pkg::CNT_W'(dbl_t - {1'b0, den_t})
                                : uvsp_pkg::CNT_W'(dbl_t);
        data_next.rem_p = bit_p ? uvsp_pkg::CNT_W'(dbl_p - {1'b0, den_p})
                                : uvsp_pkg::CNT_W'(dbl_p);
        data_next.quo_t = {in_data.quo_t[uvsp_pkg::DIV_BITS-2:0], bit_t};
        data_next.quo_p = {in_data.quo_p[uvsp_pkg::DIV_BITS-2:0], bit_p};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/uvsp_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// uvsp_cordic_cell
// One micro-rotation for both the polar and the azimuth angle.
// ----------------------------------------------------------------------------
module uvsp_cordic_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic [4:0]     stage,
    input  logic           in_valid,
    output logic           in_ready,
    input  uvsp_pkg::cor_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output uvsp_pkg::cor_t out_data
);

    logic           valid_reg;
    uvsp_pkg::cor_t data_reg;
    uvsp_pkg::cor_t data_next;
    logic signed [uvsp_pkg::ANG_W-1:0] atan_k;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign atan_k    = uvsp_pkg::atan_turn(stage);

    // Rotate toward zero residual angle
    always_comb begin
        data_next = in_data;
        if (!in_data.zt[uvsp_pkg::ANG_W-1]) begin
            data_next.xt = in_data.xt - (in_data.yt >>> stage);
            data_next.yt = in_data.yt + (in_data.xt >>> stage);
            data_next.zt = in_data.zt - atan_k;
        end else begin
            data_next.xt = in_data.xt + (in_data.yt >>> stage);
            data_next.yt = in_data.yt - (in_data.xt >>> stage);
            data_next.zt = in_data.zt + atan_k;
        end
        if (!in_data.zp[uvsp_pkg::ANG_W-1]) begin
            data_next.xp = in_data.xp - (in_data.yp >>> stage);
            data_next.yp = in_data.yp + (in_data.xp >>> stage);
            data_next.zp = in_data.zp - atan_k;
        end else begin
            data_next.xp = in_data.xp + (in_data.yp >>> stage);
            data_next.yp = in_data.yp - (in_data.xp >>> stage);
            data_next.zp = in_data.zp + atan_k;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/core/uv_sphere_point_generator.sv =====
// ----------------------------------------------------------------------------
// uv_sphere_point_generator
// Vertex and quad indices of one latitude-longitude sphere grid point.
// ----------------------------------------------------------------------------
// Takes one grid point per cycle while the pipeline is not backed up and
// returns one result per point, in order. The path is 53 register stages
// deep: the prep register for index clamping and quad index math, a chain
// of 32 long-division cells that turns both indices into binary angles,
// the quadrant fold register, a chain of 16 CORDIC cells that rotates both
// angles at once, the Multiply 1 and Multiply 2 registers and the output
// register. Every cell holds its own valid bit and passes data on whenever
// the next cell is free, so the chain keeps streaming while the output
// waits, until every stage is full. Configuration writes are taken every
// cycle and must only happen while no point is in flight; a write to index 3
// is ignored.
module uv_sphere_point_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [15:0]                         cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [8:0]                          s_ring_index,
    input  logic [8:0]                          s_segment_index,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [uvsp_pkg::COORD_W-1:0] m_x_coord,
    output logic signed [uvsp_pkg::COORD_W-1:0] m_y_coord,
    output logic signed [uvsp_pkg::COORD_W-1:0] m_z_coord,
    output logic                                m_has_quad,
    output logic [uvsp_pkg::IDX_W-1:0]          m_tri0_a,
    output logic [uvsp_pkg::IDX_W-1:0]          m_tri0_b,
    output logic [uvsp_pkg::IDX_W-1:0]          m_tri0_c,
    output logic [uvsp_pkg::IDX_W-1:0]          m_tri1_a,
    output logic [uvsp_pkg::IDX_W-1:0]          m_tri1_b,
    output logic [uvsp_pkg::IDX_W-1:0]          m_tri1_c,
    output logic                                m_last_vertex
);

    localparam int NDIV = uvsp_pkg::DIV_BITS;
    localparam int NCOR = uvsp_pkg::CORDIC_STAGES;
    localparam int W    = uvsp_pkg::ANG_W;
    localparam int PW   = uvsp_pkg::PROD_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0]                radius_reg;
    logic [uvsp_pkg::CNT_W-1:0] ring_count_reg;
    logic [uvsp_pkg::CNT_W-1:0] segment_count_reg;
    logic [uvsp_pkg::CNT_W-1:0] rings;
    logic [uvsp_pkg::CNT_W-1:0] segs;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg        <= 16'd256;
            ring_count_reg    <= 9'd16;
            segment_count_reg <= 9'd24;
        end else if (cfg_valid) begin
            case (uvsp_pkg::cfg_idx_t'(cfg_index))
                uvsp_pkg::REG_RADIUS:        radius_reg <= cfg_data;
                uvsp_pkg::REG_RING_COUNT:    ring_count_reg <= cfg_data[8:0];
                uvsp_pkg::REG_SEGMENT_COUNT: segment_count_reg <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Effective counts: zero acts as one, large values clip to the maximum
    always_comb begin
        if (ring_count_reg == '0) begin
            rings = 9'd1;
        end else if (ring_count_reg > 9'(uvsp_pkg::MAX_RINGS)) begin
            rings = 9'(uvsp_pkg::MAX_RINGS);
        end else begin
            rings = ring_count_reg;
        end
        if (segment_count_reg == '0) begin
            segs = 9'd1;
        end else if (segment_count_reg > 9'(uvsp_pkg::MAX_SEGMENTS)) begin
            segs = 9'(uvsp_pkg::MAX_SEGMENTS);
        end else begin
            segs = segment_count_reg;
        end
    end

    // ------------------------------------------------------------------
    // Ready chain, back to front
    // ------------------------------------------------------------------
    logic m_valid_reg;
    logic out_take;
    logic m2_valid_reg;
    logic m2_ready;
    logic m1_valid_reg;
    logic m1_ready;
    logic fold_valid_reg;
    logic fold_ready;
    logic prep_valid_reg;
    logic prep_ready;

    logic           div_valid [NDIV+1];
    logic           div_ready [NDIV+1];
    uvsp_pkg::div_t div_data  [NDIV+1];
    logic           cor_valid [NCOR+1];
    logic           cor_ready [NCOR+1];
    uvsp_pkg::cor_t cor_data  [NCOR+1];

    assign out_take   = !m_valid_reg || m_ready;
    assign m2_ready   = !m2_valid_reg || out_take;
    assign m1_ready   = !m1_valid_reg || m2_ready;
    assign cor_ready[NCOR] = m1_ready;
    assign fold_ready = !fold_valid_reg || cor_ready[0];
    assign div_ready[NDIV] = fold_ready;
    assign prep_ready = !prep_valid_reg || div_ready[0];
    assign s_ready    = prep_ready;

    // ------------------------------------------------------------------
    // Prep stage: clamp indices, quad indices, division start
    // ------------------------------------------------------------------
    uvsp_pkg::div_t             prep_reg;
    uvsp_pkg::div_t             prep_next;
    logic [uvsp_pkg::CNT_W-1:0] ri;
    logic [uvsp_pkg::CNT_W-1:0] si;
    logic [uvsp_pkg::IDX_W-1:0] first_idx;

    always_comb begin
        ri = (s_ring_index > rings) ? rings : s_ring_index;
        si = (s_segment_index > segs) ? segs : s_segment_index;
        first_idx = uvsp_pkg::IDX_W'(ri) * uvsp_pkg::IDX_W'({1'b0, segs} + 10'd1)
                  + uvsp_pkg::IDX_W'(si);
        prep_next.full_t = (ri == rings);
        prep_next.full_p = (si == segs);
        prep_next.rem_t  = prep_next.full_t ? '0 : ri;
        prep_next.rem_p  = prep_next.full_p ? '0 : si;
        prep_next.quo_t  = '0;
        prep_next.quo_p  = '0;
        prep_next.side.first  = first_idx;
        prep_next.side.second = first_idx + uvsp_pkg::IDX_W'(segs)
                              + uvsp_pkg::IDX_W'(1);
        prep_next.side.quad   = (ri < rings) && (si < segs);
        prep_next.side.last   = (ri == rings) && (si == segs);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (prep_ready) begin
            prep_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (prep_ready && s_valid) begin
            prep_reg <= prep_next;
        end
    end

    assign div_valid[0] = prep_valid_reg;
    assign div_data[0]  = prep_reg;

    // ------------------------------------------------------------------
    // Division chain: one quotient bit per cell
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NDIV; g++) begin : g_div
        uvsp_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[g]),
            .in_ready  (div_ready[g]),
            .in_data   (div_data[g]),
            .out_valid (div_valid[g+1]),
            .out_ready (div_ready[g+1]),
            .out_data  (div_data[g+1]),
            .den_t     (rings),
            .den_p     (segs)
        );
    end

    // ------------------------------------------------------------------
    // Fold stage: form angles, fold into the right half plane
    // ------------------------------------------------------------------
    uvsp_pkg::div_t dv;
    uvsp_pkg::cor_t fold_reg;
    uvsp_pkg::cor_t fold_next;
    logic [31:0]    ang_t;
    logic [31:0]    ang_p;
    logic [31:0]    fa_t;
    logic [31:0]    fa_p;

    assign dv = div_data[NDIV];

    always_comb begin
        ang_t = dv.full_t ? 32'h8000_0000 : {1'b0, dv.quo_t[NDIV-1:1]};
        ang_p = dv.full_p ? 32'h0 : dv.quo_p;
        fold_next.neg_t = (ang_t[31:30] == 2'b01) || (ang_t[31:30] == 2'b10);
        fold_next.neg_p = (ang_p[31:30] == 2'b01) || (ang_p[31:30] == 2'b10);
        fa_t = fold_next.neg_t ? ang_t + 32'h8000_0000 : ang_t;
        fa_p = fold_next.neg_p ? ang_p + 32'h8000_0000 : ang_p;
        fold_next.zt = {{(W-32){fa_t[31]}}, fa_t};
        fold_next.zp = {{(W-32){fa_p[31]}}, fa_p};
        fold_next.xt = uvsp_pkg::CORDIC_GAIN;
        fold_next.xp = uvsp_pkg::CORDIC_GAIN;
        fold_next.yt = '0;
        fold_next.yp = '0;
        fold_next.side = dv.side;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fold_valid_reg <= 1'b0;
        end else if (fold_ready) begin
            fold_valid_reg <= div_valid[NDIV];
        end
    end

    always_ff @(posedge aclk) begin
        if (fold_ready && div_valid[NDIV]) begin
            fold_reg <= fold_next;
        end
    end

    assign cor_valid[0] = fold_valid_reg;
    assign cor_data[0]  = fold_reg;

    // ------------------------------------------------------------------
    // CORDIC chain
    // ------------------------------------------------------------------
    for (genvar g = 0; g < NCOR; g++) begin : g_cor
        uvsp_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage     (5'(g)),
            .in_valid  (cor_valid[g]),
            .in_ready  (cor_ready[g]),
            .in_data   (cor_data[g]),
            .out_valid (cor_valid[g+1]),
            .out_ready (cor_ready[g+1]),
            .out_data  (cor_data[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Multiply 1: sin(t)cos(p), sin(t)sin(p), r cos(t)
    // ------------------------------------------------------------------
    uvsp_pkg::cor_t            cv;
    logic signed [W-1:0]       ct;
    logic signed [W-1:0]       st;
    logic signed [W-1:0]       cp;
    logic signed [W-1:0]       sp;
    logic signed [16:0]        rad_s;
    logic signed [2*W-1:0]     pxs_reg;
    logic signed [2*W-1:0]     pzs_reg;
    logic signed [PW-1:0]      pry_reg;
    uvsp_pkg::side_t           m1_side_reg;

    assign cv    = cor_data[NCOR];
    assign ct    = cv.neg_t ? -cv.xt : cv.xt;
    assign st    = cv.neg_t ? -cv.yt : cv.yt;
    assign cp    = cv.neg_p ? -cv.xp : cv.xp;
    assign sp    = cv.neg_p ? -cv.yp : cv.yp;
    assign rad_s = $signed({1'b0, radius_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_valid_reg <= 1'b0;
        end else if (m1_ready) begin
            m1_valid_reg <= cor_valid[NCOR];
        end
    end

    always_ff @(posedge aclk) begin
        if (m1_ready && cor_valid[NCOR]) begin
            pxs_reg     <= (2*W)'(st) * (2*W)'(cp);
            pzs_reg     <= (2*W)'(st) * (2*W)'(sp);
            pry_reg     <= PW'(rad_s) * PW'(ct);
            m1_side_reg <= cv.side;
        end
    end

    // ------------------------------------------------------------------
    // Multiply 2: round to Q2.30, scale by radius; finish y
    // ------------------------------------------------------------------
    logic signed [2*W-1:0]  rxs;
    logic signed [2*W-1:0]  rzs;
    logic signed [PW-1:0]   rys;
    logic signed [PW-1:0]   qx;
    logic signed [PW-1:0]   qz;
    logic signed [PW-1:0]   prx_reg;
    logic signed [PW-1:0]   prz_reg;
    logic signed [uvsp_pkg::COORD_W-1:0] y_m2_reg;
    uvsp_pkg::side_t        m2_side_reg;

    always_comb begin
        rxs = pxs_reg + (68'sd1 <<< 29);
        rzs = pzs_reg + (68'sd1 <<< 29);
        rys = pry_reg + (53'sd1 <<< 29);
        qx  = PW'(rxs >>> 30);
        qz  = PW'(rzs >>> 30);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_valid_reg <= 1'b0;
        end else if (m2_ready) begin
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (m2_ready && m1_valid_reg) begin
            prx_reg     <= PW'(rad_s) * qx;
            prz_reg     <= PW'(rad_s) * qz;
            y_m2_reg    <= uvsp_pkg::sat_coord(rys >>> 30);
            m2_side_reg <= m1_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output register: round x and z, expand triangle indices
    // ------------------------------------------------------------------
    logic signed [PW-1:0] rxo;
    logic signed [PW-1:0] rzo;
    logic [uvsp_pkg::IDX_W-1:0] f_idx;
    logic [uvsp_pkg::IDX_W-1:0] s_idx;
    logic                       qd;

    assign rxo   = prx_reg + (53'sd1 <<< 29);
    assign rzo   = prz_reg + (53'sd1 <<< 29);
    assign f_idx = m2_side_reg.first;
    assign s_idx = m2_side_reg.second;
    assign qd    = m2_side_reg.quad;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_take) begin
            m_valid_reg <= m2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_take && m2_valid_reg) begin
            m_x_coord     <= uvsp_pkg::sat_coord(rxo >>> 30);
            m_y_coord     <= y_m2_reg;
            m_z_coord     <= uvsp_pkg::sat_coord(rzo >>> 30);
            m_has_quad    <= qd;
            m_tri0_a      <= qd ? f_idx : '0;
            m_tri0_b      <= qd ? s_idx : '0;
            m_tri0_c      <= qd ? f_idx + 17'd1 : '0;
            m_tri1_a      <= qd ? s_idx : '0;
            m_tri1_b      <= qd ? s_idx + 17'd1 : '0;
            m_tri1_c      <= qd ? f_idx + 17'd1 : '0;
            m_last_vertex <= m2_side_reg.last;
        end
    end

    assign m_valid = m_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input is held back only when every stage is full and output stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while pipeline has room");

    // No quad means all triangle indices are zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_quad) |->
        (m_tri0_a == '0 && m_tri0_b == '0 && m_tri0_c == '0 &&
         m_tri1_a == '0 && m_tri1_b == '0 && m_tri1_c == '0))
        else $error("triangle indices set without a quad");

    // The final grid point never starts a quad
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_last_vertex) |-> !m_has_quad)
        else $error("last vertex flagged with a quad");

    // A stalled result holds until its transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_tri0_a)
                                   && $stable(m_x_coord)))
        else $error("output changed while stalled");

endmodule
